// File: src/ami_pkg.sv
package ami_pkg;

   localparam int FIELD_W = 64;
   localparam int EXP_W   = 8;
   localparam int STEP_W  = 2;
   localparam int PROG_LEN = 4;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_LOAD   = 2'd0;
   localparam step_type STEP_ITER   = 2'd1;
   localparam step_type STEP_REDUCE = 2'd2;
   localparam step_type STEP_EMIT   = 2'd3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ITER,
      OP_REDUCE,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ_BEAT,
      COND_LOOP_DONE,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ctrl_word_type;

   // control store: one word per step
   localparam ctrl_word_type PROGRAM [PROG_LEN] = '{
      '{op: OP_LOAD,   cond: COND_REQ_BEAT,  on_true: STEP_ITER,   on_false: STEP_LOAD},
      '{op: OP_ITER,   cond: COND_LOOP_DONE, on_true: STEP_REDUCE, on_false: STEP_ITER},
      '{op: OP_REDUCE, cond: COND_ALWAYS,    on_true: STEP_EMIT,   on_false: STEP_EMIT},
      '{op: OP_EMIT,   cond: COND_OUT_FREE,  on_true: STEP_LOAD,   on_false: STEP_EMIT}
   };

endpackage

// File: src/almost_montgomery_inverse.sv
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  req_operand
// rsp      out        rsp_valid / rsp_stall  rsp_inverse, rsp_exponent
// csr      in         csr_wr_en              csr_modulus
//
// A beat passes the load step, the loop steps until k reaches 2 * WIDTH or v is zero, the
// step that sees the loop end, reduction, and the emit step that loads the result register.
// Reset is synchronous; it returns the sequencer to the load step, empties the result
// register and sets the modulus to 1.
// A stalled result holds in its register; the next beat is taken meanwhile and waits
// in the emit step only if the result register is still full and stalled.
module almost_montgomery_inverse #(
   parameter int WIDTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ami_pkg::FIELD_W-1:0]         req_operand,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ami_pkg::FIELD_W-1:0]         rsp_inverse,
   output logic [ami_pkg::EXP_W-1:0]           rsp_exponent,
   input  logic                                csr_wr_en,
   input  logic [ami_pkg::FIELD_W-1:0]         csr_modulus
);
   import ami_pkg::*;

   localparam int KW = $clog2(2 * WIDTH + 1);
   localparam logic [KW-1:0] K_MAX = KW'(2 * WIDTH);

   step_type              step_ff, step_in;
   logic [WIDTH-1:0]      modulus_ff, modulus_in;
   logic [WIDTH-1:0]      u_ff, u_in;
   logic [WIDTH-1:0]      v_ff, v_in;
   logic [WIDTH-1:0]      s_ff, s_in;
   logic [WIDTH:0]        t_ff, t_in;
   logic [KW-1:0]         k_ff, k_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]      rsp_inverse_ff, rsp_inverse_in;
   logic [KW-1:0]         rsp_exponent_ff, rsp_exponent_in;

   ctrl_word_type         ctrl;
   logic                  cond_true;
   logic                  req_beat;
   logic                  loop_done;
   logic                  out_free;
   logic                  u_gt_v;
   logic [WIDTH-1:0]      u_minus_v;
   logic [WIDTH-1:0]      v_minus_u;
   logic [WIDTH:0]        t_plus_s;
   logic [WIDTH+1:0]      t_minus_m;
   logic                  no_inverse;

   assign ctrl      = PROGRAM[step_ff];
   assign req_stall = (ctrl.op != OP_LOAD);
   assign req_beat  = req_valid && !req_stall;
   assign loop_done = (v_ff == '0) || (k_ff == K_MAX);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign u_gt_v     = (u_ff > v_ff);
   assign u_minus_v  = u_ff - v_ff;
   assign v_minus_u  = v_ff - u_ff;
   assign t_plus_s   = t_ff + {1'b0, s_ff};
   assign t_minus_m  = {1'b0, t_ff} - {2'b00, modulus_ff};
   assign no_inverse = (v_ff != '0) || (u_ff != WIDTH'(1));

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:    cond_true = 1'b1;
         COND_REQ_BEAT:  cond_true = req_beat;
         COND_LOOP_DONE: cond_true = loop_done;
         COND_OUT_FREE:  cond_true = out_free;
         default:        cond_true = 1'b1;
      endcase
   end

   always_comb begin
      step_in         = cond_true ? ctrl.on_true : ctrl.on_false;
      modulus_in      = csr_wr_en ? csr_modulus[WIDTH-1:0] : modulus_ff;
      u_in            = u_ff;
      v_in            = v_ff;
      s_in            = s_ff;
      t_in            = t_ff;
      k_in            = k_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_inverse_in  = rsp_inverse_ff;
      rsp_exponent_in = rsp_exponent_ff;

      case (ctrl.op)
         OP_LOAD: begin
            if (req_beat) begin
               u_in = modulus_ff;
               v_in = req_operand[WIDTH-1:0];
               s_in = WIDTH'(1);
               t_in = '0;
               k_in = '0;
            end
         end
         OP_ITER: begin
            if (!loop_done) begin
               k_in = k_ff + KW'(1);
               if (!u_ff[0]) begin
                  u_in = u_ff >> 1;
                  s_in = s_ff << 1;
               end else if (!v_ff[0]) begin
                  v_in = v_ff >> 1;
                  t_in = {t_ff[WIDTH-1:0], 1'b0};
               end else if (u_gt_v) begin
                  u_in = u_minus_v >> 1;
                  t_in = t_plus_s;
                  s_in = s_ff << 1;
               end else begin
                  v_in = v_minus_u >> 1;
                  s_in = s_ff + t_ff[WIDTH-1:0];
                  t_in = {t_ff[WIDTH-1:0], 1'b0};
               end
            end
         end
         OP_REDUCE: begin
            if (!t_minus_m[WIDTH+1]) begin
               t_in = {1'b0, t_minus_m[WIDTH-1:0]};
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_inverse_in  = no_inverse ? '0 : (modulus_ff - t_ff[WIDTH-1:0]);
               rsp_exponent_in = no_inverse ? '0 : k_ff;
            end
         end
         default: begin
            u_in = u_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_LOAD;
         modulus_ff   <= WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      u_ff            <= u_in;
      v_ff            <= v_in;
      s_ff            <= s_in;
      t_ff            <= t_in;
      k_ff            <= k_in;
      rsp_inverse_ff  <= rsp_inverse_in;
      rsp_exponent_ff <= rsp_exponent_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_inverse  = FIELD_W'(rsp_inverse_ff);
   assign rsp_exponent = EXP_W'(rsp_exponent_ff);

   a_k_bounded: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_ITER) |-> (k_ff <= K_MAX))
      else $error("step count past its limit");

   a_load_starts_loop: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (step_ff == STEP_ITER) && (k_ff == '0) && (s_ff == WIDTH'(1)))
      else $error("beat did not start the loop");

   a_iter_counts: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_ITER) && !loop_done |=> (k_ff == $past(k_ff) + KW'(1)))
      else $error("loop step not counted");

   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_EMIT) && out_free |=> rsp_valid_ff && (step_ff == STEP_LOAD))
      else $error("emit step did not load the result register");

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_REDUCE) |=> (t_ff[WIDTH] == 1'b0))
      else $error("t not reduced below 2^WIDTH");

endmodule
